FILE: rtl/gcd_pkg.sv
// Shared types, widths, constants and arithmetic helpers of the great circle distance unit.
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

    localparam int LAT_W  = 30;
    localparam int LON_W  = 31;
    localparam int ANG_W  = 30;
    localparam int DIST_W = 34;
    localparam int RAD_W  = 32;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STAGES   = 32;
    localparam int BACK_LAT      = 2 * CORDIC_STAGES + 41;

    localparam int AW  = 36;
    localparam int SCW = 32;
    localparam int CW  = 36;
    localparam int VW  = 34;
    localparam int RW  = 36;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [CW-1:0] KINV_Q30    = 36'sd652032874;
    localparam logic [RAD_W-1:0]     RADIUS_RESET = 32'd417647493;

    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [SCW-1:0] ang;
        logic                  neg;
    } red_angle_t;

    typedef struct packed {
        red_angle_t lat_a;
        red_angle_t lat_b;
        red_angle_t dlon;
    } queue_item_t;

    function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
        return signed'(CW'(ATAN_TAB[5'(i)]));
    endfunction

    // Arithmetic shift that truncates toward zero.
    function automatic logic signed [CW-1:0] shr0(input logic signed [CW-1:0] v,
                                                  input int unsigned s);
        return (v < 0) ? -((-v) >>> s) : (v >>> s);
    endfunction

    // Q30 product, truncated toward zero.
    function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
        logic signed [2*VW-1:0] p;
        logic signed [2*VW-1:0] q;
        p = a * b;
        q = (p < 0) ? -((-p) >>> 30) : (p >>> 30);
        return q[VW-1:0];
    endfunction

    // Moves an angle in [-pi, pi] into [-pi/2, pi/2] and flags the half turn.
    function automatic red_angle_t fold_half(input logic signed [AW-1:0] a);
        red_angle_t             r;
        logic signed [AW-1:0]   t;
        t     = a;
        r.neg = 1'b0;
        if (a > HALF_PI_Q30)
        begin
            t     = a - PI_Q30;
            r.neg = 1'b1;
        end
        else if (a < -HALF_PI_Q30)
        begin
            t     = a + PI_Q30;
            r.neg = 1'b1;
        end
        r.ang = t[SCW-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gcd_intf.sv
// Channel interfaces of the great circle distance unit: point pairs, results and radius writes.
`timescale 1ns / 1ps
`default_nettype none

interface gcd_point_if;
    import gcd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;
    modport source (output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                    input ready);
    modport sink (input valid, input lat_a, input lon_a, input lat_b, input lon_b,
                  output ready);
endinterface

interface gcd_result_if;
    import gcd_pkg::*;
    logic               valid;
    logic               ready;
    logic [ANG_W-1:0]   central_angle;
    logic [DIST_W-1:0]  distance_q16;
    modport source (output valid, output central_angle, output distance_q16, input ready);
    modport sink (input valid, input central_angle, input distance_q16, output ready);
endinterface

interface gcd_cfg_if;
    import gcd_pkg::*;
    logic              valid;
    logic              ready;
    logic [RAD_W-1:0]  sphere_radius_q16;
    modport source (output valid, output sphere_radius_q16, input ready);
    modport sink (input valid, input sphere_radius_q16, output ready);
endinterface

`default_nettype wire

FILE: rtl/great_circle_distance_unit.sv
// Top level of the great circle distance unit: front end, queue, back end and radius register.
//
//   Channel   Direction  Carries
//   points    in         lat_a, lat_b (signed Q1.28 radians), lon_a, lon_b (signed Q2.28 radians)
//   result    out        central_angle (Q2.28), distance_q16 (18.16 km)
//   cfg       in         sphere_radius_q16 (16.16 km)
//
// One point pair is accepted per cycle while the front end is not stalled; each then passes
// the queue, the two CORDIC pipelines and the 32-stage square root on the way to its result.
// Reset sets the radius to 6372.795 km and empties every stage and the four-entry queue.
// A stalled result freezes the back end; the front end keeps accepting until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module great_circle_distance_unit (
    input  wire          clk,
    input  wire          rst_n,
    gcd_point_if.sink    points,
    gcd_result_if.source result,
    gcd_cfg_if.sink      cfg
);
    import gcd_pkg::*;

    logic [RAD_W-1:0] radius_reg;
    queue_item_t      front_item;
    logic             front_valid;
    logic             front_ready;
    queue_item_t      back_item;
    logic             back_valid;
    logic             back_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg.valid)
        begin
            radius_reg <= cfg.sphere_radius_q16;
        end
    end

    gcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .points     (points),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    gcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    gcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .radius     (radius_reg),
        .result     (result)
    );

endmodule

`default_nettype wire

FILE: rtl/gcd_front.sv
// Front end: accepts point pairs, reduces the three angles and classifies their half turn.
`timescale 1ns / 1ps
`default_nettype none

module gcd_front (
    input  wire                  clk,
    input  wire                  rst_n,
    gcd_point_if.sink            points,
    output gcd_pkg::queue_item_t item,
    output logic                 item_valid,
    input  wire                  item_ready
);
    import gcd_pkg::*;

    logic                  en;
    logic                  f0_valid_reg;
    logic                  f1_valid_reg;
    logic                  f2_valid_reg;
    logic                  f3_valid_reg;
    logic signed [AW-1:0]  la0_reg, lb0_reg, dl0_reg;
    logic signed [AW-1:0]  la1_reg, lb1_reg, dm1_reg;
    logic                  ds1_reg;
    logic signed [AW-1:0]  la2_reg, lb2_reg, dl2_reg;
    queue_item_t           item_reg;
    logic signed [AW-1:0]  dl_mag;
    logic signed [AW-1:0]  dl_signed;
    logic signed [AW-1:0]  dl_wrapped;

    assign en           = !f3_valid_reg || item_ready;
    assign points.ready = en;
    assign item_valid   = f3_valid_reg;
    assign item         = item_reg;

    always_comb
    begin
        dl_mag    = (dl0_reg < 0) ? -dl0_reg : dl0_reg;
        dl_signed = ds1_reg ? -dm1_reg : dm1_reg;
        if (dl_signed > PI_Q30)
        begin
            dl_wrapped = dl_signed - TWO_PI_Q30;
        end
        else if (dl_signed < -PI_Q30)
        begin
            dl_wrapped = dl_signed + TWO_PI_Q30;
        end
        else
        begin
            dl_wrapped = dl_signed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f0_valid_reg <= points.valid;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la0_reg <= AW'(points.lat_a) <<< 2;
            lb0_reg <= AW'(points.lat_b) <<< 2;
            dl0_reg <= (AW'(points.lon_b) - AW'(points.lon_a)) <<< 2;

            la1_reg <= la0_reg;
            lb1_reg <= lb0_reg;
            ds1_reg <= dl0_reg < 0;
            dm1_reg <= (dl_mag >= TWO_PI_Q30) ? dl_mag - TWO_PI_Q30 : dl_mag;

            la2_reg <= la1_reg;
            lb2_reg <= lb1_reg;
            dl2_reg <= dl_wrapped;

            item_reg.lat_a <= fold_half(la2_reg);
            item_reg.lat_b <= fold_half(lb2_reg);
            item_reg.dlon  <= fold_half(dl2_reg);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gcd_queue.sv
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module gcd_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  gcd_pkg::queue_item_t in_item,
    output logic                 out_valid,
    input  wire                  out_ready,
    output gcd_pkg::queue_item_t out_item
);
    import gcd_pkg::*;

    queue_item_t      mem_reg [0:QDEPTH-1];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != (QAW+1)'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gcd_sincos.sv
// Pipelined rotation CORDIC giving the sine and cosine of one reduced angle.
`timescale 1ns / 1ps
`default_nettype none

module gcd_sincos (
    input  wire                      clk,
    input  wire                      en,
    input  gcd_pkg::red_angle_t      angle,
    output logic signed [gcd_pkg::VW-1:0] sin_q30,
    output logic signed [gcd_pkg::VW-1:0] cos_q30
);
    import gcd_pkg::*;

    logic signed [CW-1:0] x_reg [1:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [1:CORDIC_STAGES];
    logic signed [CW-1:0] z_reg [1:CORDIC_STAGES];
    logic                 neg_reg [1:CORDIC_STAGES];
    logic signed [VW-1:0] sin_reg;
    logic signed [VW-1:0] cos_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [CW-1:0] xc, yc, zc, xs, ys;
        logic                 nc;
        if (i == 0)
        begin : g_first
            assign xc = KINV_Q30;
            assign yc = '0;
            assign zc = CW'(angle.ang);
            assign nc = angle.neg;
        end
        else
        begin : g_next
            assign xc = x_reg[i];
            assign yc = y_reg[i];
            assign zc = z_reg[i];
            assign nc = neg_reg[i];
        end
        assign xs = shr0(xc, i);
        assign ys = shr0(yc, i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= nc;
                if (zc >= 0)
                begin
                    x_reg[i+1] <= xc - ys;
                    y_reg[i+1] <= yc + xs;
                    z_reg[i+1] <= zc - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= xc + ys;
                    y_reg[i+1] <= yc - xs;
                    z_reg[i+1] <= zc + atan_q30(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= VW'(neg_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES]);
            cos_reg <= VW'(neg_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES]);
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

`default_nettype wire

FILE: rtl/gcd_back.sv
// Back end: sine/cosine CORDICs, products, square root, vectoring CORDIC, scaling and the output register.
`timescale 1ns / 1ps
`default_nettype none

module gcd_back (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       item_valid,
    output logic                      item_ready,
    input  gcd_pkg::queue_item_t      item,
    input  wire [gcd_pkg::RAD_W-1:0]  radius,
    gcd_result_if.source              result
);
    import gcd_pkg::*;

    logic                  en;
    logic [BACK_LAT-1:0]   vld_reg;

    logic signed [VW-1:0]  slat1, clat1, slat2, clat2, sdl, cdl;
    logic signed [VW-1:0]  t1_reg, cc_reg, pc_reg, pd_reg, sl1_reg, cl1_reg;
    logic signed [VW-1:0]  q1_reg, q2_reg, t1b_reg, pc2_reg, pd2_reg;
    logic signed [VW-1:0]  t1c_reg, t2_reg, t3_reg;
    logic [63:0]           sq1_reg, sq2_reg;
    logic signed [VW-1:0]  t3b_reg, t3c_reg;
    logic [63:0]           sum_reg;
    logic signed [2*VW-1:0] sq1_full, sq2_full;

    logic [RW-1:0]         rem_reg  [1:SQRT_STAGES];
    logic [31:0]           root_reg [1:SQRT_STAGES];
    logic [63:0]           val_reg  [1:SQRT_STAGES];
    logic signed [VW-1:0]  t3s_reg  [1:SQRT_STAGES];

    logic signed [CW-1:0]  px_reg, py_reg, pz_reg;
    logic signed [CW-1:0]  root_ext, t3_ext;

    logic signed [CW-1:0]  vx_reg [1:CORDIC_STAGES];
    logic signed [CW-1:0]  vy_reg [1:CORDIC_STAGES];
    logic signed [CW-1:0]  vz_reg [1:CORDIC_STAGES];

    logic signed [CW-1:0]  z_clamp, z_round;
    logic [ANG_W-1:0]      ang_reg;
    logic [62:0]           dist_sum;
    logic [ANG_W-1:0]      ca_out_reg;
    logic [DIST_W-1:0]     dist_out_reg;

    assign en         = !vld_reg[BACK_LAT-1] || result.ready;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[BACK_LAT-2:0], item_valid};
        end
    end

    gcd_sincos u_lat_a (.clk(clk), .en(en), .angle(item.lat_a), .sin_q30(slat1), .cos_q30(clat1));
    gcd_sincos u_lat_b (.clk(clk), .en(en), .angle(item.lat_b), .sin_q30(slat2), .cos_q30(clat2));
    gcd_sincos u_dlon  (.clk(clk), .en(en), .angle(item.dlon),  .sin_q30(sdl),   .cos_q30(cdl));

    assign sq1_full = t1c_reg * t1c_reg;
    assign sq2_full = t2_reg * t2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= mulq(clat2, sdl);
            cc_reg  <= mulq(clat2, cdl);
            pc_reg  <= mulq(clat1, slat2);
            pd_reg  <= mulq(slat1, slat2);
            sl1_reg <= slat1;
            cl1_reg <= clat1;

            q1_reg  <= mulq(sl1_reg, cc_reg);
            q2_reg  <= mulq(cl1_reg, cc_reg);
            t1b_reg <= t1_reg;
            pc2_reg <= pc_reg;
            pd2_reg <= pd_reg;

            t1c_reg <= t1b_reg;
            t2_reg  <= pc2_reg - q1_reg;
            t3_reg  <= pd2_reg + q2_reg;

            sq1_reg <= sq1_full[63:0];
            sq2_reg <= sq2_full[63:0];
            t3b_reg <= t3_reg;

            sum_reg <= sq1_reg + sq2_reg;
            t3c_reg <= t3b_reg;
        end
    end

    // Square root, one result bit per stage.
    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        logic [RW-1:0]        rc, cur, trial;
        logic [31:0]          qc;
        logic [63:0]          vc;
        logic signed [VW-1:0] tc;
        if (k == 0)
        begin : g_first
            assign rc = '0;
            assign qc = '0;
            assign vc = sum_reg;
            assign tc = t3c_reg;
        end
        else
        begin : g_next
            assign rc = rem_reg[k];
            assign qc = root_reg[k];
            assign vc = val_reg[k];
            assign tc = t3s_reg[k];
        end
        assign cur   = {rc[RW-3:0], vc[63:62]};
        assign trial = RW'({qc, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[k+1] <= vc << 2;
                t3s_reg[k+1] <= tc;
                if (cur >= trial)
                begin
                    rem_reg[k+1]  <= cur - trial;
                    root_reg[k+1] <= {qc[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= cur;
                    root_reg[k+1] <= {qc[30:0], 1'b0};
                end
            end
        end
    end

    assign root_ext = signed'(CW'(root_reg[SQRT_STAGES]));
    assign t3_ext   = CW'(t3s_reg[SQRT_STAGES]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (t3_ext < 0)
            begin
                px_reg <= root_ext;
                py_reg <= -t3_ext;
                pz_reg <= CW'(HALF_PI_Q30);
            end
            else
            begin
                px_reg <= t3_ext;
                py_reg <= root_ext;
                pz_reg <= '0;
            end
        end
    end

    // Vectoring CORDIC for the arctangent.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_vec
        logic signed [CW-1:0] xc, yc, zc, xs, ys;
        if (i == 0)
        begin : g_first
            assign xc = px_reg;
            assign yc = py_reg;
            assign zc = pz_reg;
        end
        else
        begin : g_next
            assign xc = vx_reg[i];
            assign yc = vy_reg[i];
            assign zc = vz_reg[i];
        end
        assign xs = shr0(xc, i);
        assign ys = shr0(yc, i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yc > 0)
                begin
                    vx_reg[i+1] <= xc + ys;
                    vy_reg[i+1] <= yc - xs;
                    vz_reg[i+1] <= zc + atan_q30(i);
                end
                else if (yc < 0)
                begin
                    vx_reg[i+1] <= xc - ys;
                    vy_reg[i+1] <= yc + xs;
                    vz_reg[i+1] <= zc - atan_q30(i);
                end
                else
                begin
                    vx_reg[i+1] <= xc;
                    vy_reg[i+1] <= yc;
                    vz_reg[i+1] <= zc;
                end
            end
        end
    end

    always_comb
    begin
        if (vz_reg[CORDIC_STAGES] < 0)
        begin
            z_clamp = '0;
        end
        else if (vz_reg[CORDIC_STAGES] > CW'(PI_Q30))
        begin
            z_clamp = CW'(PI_Q30);
        end
        else
        begin
            z_clamp = vz_reg[CORDIC_STAGES];
        end
        z_round  = z_clamp + CW'(2);
        dist_sum = 63'(ang_reg) * 63'(radius) + (63'(1) << 27);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg      <= z_round[31:2];
            ca_out_reg   <= ang_reg;
            dist_out_reg <= dist_sum[61:28];
        end
    end

    assign result.valid         = vld_reg[BACK_LAT-1];
    assign result.central_angle = ca_out_reg;
    assign result.distance_q16  = dist_out_reg;

endmodule

`default_nettype wire

FILE: tb/great_circle_distance_unit_tb.sv
// Self-checking testbench of the great circle distance unit with directed and random traffic.
`timescale 1ns / 1ps

module great_circle_distance_unit_tb;
    import gcd_pkg::*;

    localparam int LATENCY     = 2 * CORDIC_STAGES + 45;
    localparam int CYCLE_LIMIT = 900000;
    localparam int N_RANDOM    = 1800;
    localparam logic signed [LAT_W-1:0] LAT_MAX = 30'sd421657428;
    localparam logic signed [LON_W-1:0] LON_MAX = 31'sd843314857;
    localparam logic signed [63:0] PI64   = 64'sd3373259426;
    localparam logic signed [63:0] HPI64  = 64'sd1686629713;
    localparam logic signed [63:0] TPI64  = 64'sd6746518852;
    localparam logic signed [63:0] KINV64 = 64'sd652032874;

    typedef struct packed {
        logic signed [LAT_W-1:0] lat_a;
        logic signed [LON_W-1:0] lon_a;
        logic signed [LAT_W-1:0] lat_b;
        logic signed [LON_W-1:0] lon_b;
    } point_pair_t;

    typedef struct packed {
        logic [ANG_W-1:0]  central_angle;
        logic [DIST_W-1:0] distance_q16;
    } distance_t;

    typedef struct packed {
        point_pair_t pair;
        logic        known;
        distance_t   res;
    } pair_row_t;

    logic clk = 1'b0;
    logic rst_n;
    gcd_point_if  points ();
    gcd_result_if result ();
    gcd_cfg_if    cfg ();

    great_circle_distance_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    logic [RAD_W-1:0] radius;
    distance_t        pending_distances[$];
    int               errors;
    int               cycles;
    bit               stall_long;
    pair_row_t        pair_table[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v, input int s);
        return (v < 0) ? -((-v) >>> s) : (v >>> s);
    endfunction

    function automatic logic signed [63:0] q30_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        return trunc_shr(a * b, 30);
    endfunction

    function automatic logic signed [63:0] arctan_entry(input int i);
        return signed'({32'd0, ATAN_TAB[i]});
    endfunction

    task automatic rotate_sincos(input logic signed [63:0] a, output logic signed [63:0] s,
                                 output logic signed [63:0] c);
        logic signed [63:0] x, y, z, xs, ys;
        bit flip;
        flip = 0;
        x = KINV64;
        y = 0;
        a = a % TPI64;
        if (a > PI64) a = a - TPI64;
        if (a < -PI64) a = a + TPI64;
        if (a > HPI64)
        begin
            a = a - PI64;
            flip = 1;
        end
        else if (a < -HPI64)
        begin
            a = a + PI64;
            flip = 1;
        end
        z = a;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = trunc_shr(x, i);
            ys = trunc_shr(y, i);
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_entry(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_entry(i);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] vector_angle(input logic signed [63:0] y,
                                                        input logic signed [63:0] x);
        logic signed [63:0] z, t, xs, ys;
        z = 0;
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = HPI64;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = trunc_shr(x, i);
            ys = trunc_shr(y, i);
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_entry(i);
            end
            else if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_entry(i);
            end
        end
        return z;
    endfunction

    task automatic predict_distance(input point_pair_t p, output distance_t d);
        logic signed [63:0] s1, c1, s2, c2, sd, cd, t1, t2, t3, z, c2cd;
        logic [63:0] sq, ang;
        logic [95:0] dist_full;
        rotate_sincos(64'(p.lat_a) * 4, s1, c1);
        rotate_sincos(64'(p.lat_b) * 4, s2, c2);
        rotate_sincos(64'(p.lon_b) * 4 - 64'(p.lon_a) * 4, sd, cd);
        c2cd = q30_mul(c2, cd);
        t1 = q30_mul(c2, sd);
        t2 = q30_mul(c1, s2) - q30_mul(s1, c2cd);
        t3 = q30_mul(s1, s2) + q30_mul(c1, c2cd);
        sq = 64'(t1 * t1) + 64'(t2 * t2);
        z = vector_angle(signed'(floor_sqrt(sq)), t3);
        if (z < 0) z = 0;
        if (z > PI64) z = PI64;
        ang = (64'(z) + 64'd2) >> 2;
        dist_full = ({32'd0, ang} * {64'd0, radius} + (96'd1 << 27)) >> 28;
        d.central_angle = ang[ANG_W-1:0];
        d.distance_q16  = dist_full[DIST_W-1:0];
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_pair(input point_pair_t p);
        distance_t d;
        int        gap;
        gap = gap_length();
        if (gap > 0)
        begin
            points.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        points.valid <= 1'b1;
        points.lat_a <= p.lat_a;
        points.lon_a <= p.lon_a;
        points.lat_b <= p.lat_b;
        points.lon_b <= p.lon_b;
        do @(posedge clk); while (!points.ready);
        predict_distance(p, d);
        pending_distances.push_back(d);
        @(negedge clk);
    endtask

    task automatic write_radius(input logic [RAD_W-1:0] r);
        points.valid <= 1'b0;
        while (pending_distances.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.sphere_radius_q16 <= r;
        do @(posedge clk); while (!cfg.ready);
        radius = r;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [LAT_W-1:0] random_lat();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return LAT_W'($urandom());
        if (r == 1) return ($urandom_range(0, 1)) ? LAT_MAX : -LAT_MAX;
        return LAT_W'(signed'($urandom_range(0, 2 * 421657428)) - 421657428);
    endfunction

    function automatic logic signed [LON_W-1:0] random_lon();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return LON_W'($urandom());
        if (r == 1) return ($urandom_range(0, 1)) ? LON_MAX : -LON_MAX;
        return LON_W'(signed'(64'($urandom_range(0, 1686629714)) - 64'sd843314857));
    endfunction

    function automatic pair_row_t table_row(input logic signed [LAT_W-1:0] la,
                                            input logic signed [LON_W-1:0] oa,
                                            input logic signed [LAT_W-1:0] lb,
                                            input logic signed [LON_W-1:0] ob,
                                            input logic known, input logic [ANG_W-1:0] ang,
                                            input logic [DIST_W-1:0] dist_exp);
        pair_row_t r;
        r.pair = '{la, oa, lb, ob};
        r.known = known;
        r.res = '{ang, dist_exp};
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (stall_long && $urandom_range(0, 99) < 85)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 299) == 0) stall_long <= ~stall_long;
    end

    always @(posedge clk)
    begin
        distance_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_distances.size() == 0)
            begin
                $display("%0t: unexpected transaction angle %0d distance %0d", $time,
                         result.central_angle, result.distance_q16);
                errors++;
            end
            else
            begin
                want = pending_distances.pop_front();
                if (result.central_angle !== want.central_angle)
                begin
                    $display("%0t: central_angle expected %0d actual %0d", $time,
                             want.central_angle, result.central_angle);
                    errors++;
                end
                if (result.distance_q16 !== want.distance_q16)
                begin
                    $display("%0t: distance_q16 expected %0d actual %0d", $time,
                             want.distance_q16, result.distance_q16);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        point_pair_t p;
        distance_t   d;
        int          guard;
        errors = 0;
        cycles = 0;
        stall_long = 0;
        radius = RADIUS_RESET;
        rst_n = 1'b0;
        points.valid = 1'b0;
        points.lat_a = '0;
        points.lon_a = '0;
        points.lat_b = '0;
        points.lon_b = '0;
        cfg.valid = 1'b0;
        cfg.sphere_radius_q16 = '0;
        result.ready = 1'b0;

        pair_table.push_back(table_row(0, 0, 0, 0, 0, 0, 0));
        pair_table.push_back(table_row(LAT_MAX, 0, LAT_MAX, 0, 0, 0, 0));
        pair_table.push_back(table_row(LAT_MAX, 0, -LAT_MAX, 0, 0, 0, 0));
        pair_table.push_back(table_row(0, -LON_MAX, 0, LON_MAX, 0, 0, 0));
        pair_table.push_back(table_row(0, LON_MAX, 0, -LON_MAX, 0, 0, 0));
        pair_table.push_back(table_row(0, 0, 0, 31'sd843314857, 0, 0, 0));
        pair_table.push_back(table_row(0, 0, 0, 31'sd421657428, 0, 0, 0));
        pair_table.push_back(table_row(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 0, 0, 0));
        pair_table.push_back(table_row(30'sd536870911, 0, 30'sh20000000, 0, 0, 0, 0));
        pair_table.push_back(table_row(0, 31'sd1073741823, 0, 31'sh40000000, 0, 0, 0));
        pair_table.push_back(table_row(30'sd100000000, 31'sd200000000, 30'sd100000000,
                                       31'sd200000000, 0, 0, 0));
        pair_table.push_back(table_row(30'sd1, 0, 0, 31'sd1, 0, 0, 0));
        pair_table.push_back(table_row(0, 0, 0, 31'sd843314856, 0, 0, 0));
        pair_table.push_back(table_row(-30'sd300000000, 31'sd700000000, 30'sd250000000,
                                       -31'sd600000000, 0, 0, 0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (pair_table[i])
        begin
            send_pair(pair_table[i].pair);
            if (pair_table[i].known)
            begin
                d = pending_distances[$];
                if (d !== pair_table[i].res)
                begin
                    $display("%0t: table row %0d expected %h actual prediction %h", $time,
                             i, pair_table[i].res, d);
                    errors++;
                end
            end
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_radius(32'd65536);
                1: write_radius(32'hFFFFFFFF);
                2: write_radius($urandom_range(65536, 32'hFFFFFFFF));
                default: write_radius(RADIUS_RESET);
            endcase
            for (int n = 0; n < N_RANDOM / 4; n++)
            begin
                p.lat_a = random_lat();
                p.lon_a = random_lon();
                p.lat_b = random_lat();
                p.lon_b = random_lon();
                send_pair(p);
            end
        end
        points.valid <= 1'b0;

        guard = 0;
        while (pending_distances.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0 && pending_distances.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
